[hdl/dtq_pkg.sv]
package dtq_pkg;

  typedef logic [3:0] dp_op_t;

  localparam dp_op_t OP_NONE      = 4'd0;
  localparam dp_op_t OP_LOAD      = 4'd1;
  localparam dp_op_t OP_CLEAR     = 4'd2;
  localparam dp_op_t OP_RD_POS    = 4'd3;
  localparam dp_op_t OP_WALK_STEP = 4'd4;
  localparam dp_op_t OP_RD_SHIFT  = 4'd5;
  localparam dp_op_t OP_WR_SHIFT  = 4'd6;
  localparam dp_op_t OP_WR_NEW    = 4'd7;
  localparam dp_op_t OP_WR_SUCC   = 4'd8;
  localparam dp_op_t OP_COMMIT    = 4'd9;
  localparam dp_op_t OP_REJECT    = 4'd10;
  localparam dp_op_t OP_RD_HEAD   = 4'd11;
  localparam dp_op_t OP_TICK_POP  = 4'd12;
  localparam dp_op_t OP_TICK_SUB  = 4'd13;
  localparam dp_op_t OP_TICK_LAST = 4'd14;

  typedef struct packed {
    dp_op_t op;
  } dtq_ctl_t;

  typedef struct packed {
    logic full;
    logic walk_end;
    logic walk_hit;
    logic shift_done;
    logic pos_lt_len;
    logic q_empty;
    logic head_expire;
    logic pend_valid;
    logic out_free;
  } dtq_sts_t;

endpackage

[hdl/dtq_ctrl.sv]
module dtq_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  output logic             in_tready,
  input  logic [1:0]       in_command,
  input  dtq_pkg::dtq_sts_t sts,
  output dtq_pkg::dtq_ctl_t ctl
);

  localparam logic [1:0] CMD_PLAY  = 2'd0;
  localparam logic [1:0] CMD_TICK  = 2'd1;
  localparam logic [1:0] CMD_CLEAR = 2'd2;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_CLR   = 4'd1;
  localparam logic [3:0] S_PCHK  = 4'd2;
  localparam logic [3:0] S_PWALK = 4'd3;
  localparam logic [3:0] S_PCMP  = 4'd4;
  localparam logic [3:0] S_SHCHK = 4'd5;
  localparam logic [3:0] S_SHWR  = 4'd6;
  localparam logic [3:0] S_WNEW  = 4'd7;
  localparam logic [3:0] S_WSUCC = 4'd8;
  localparam logic [3:0] S_PDONE = 4'd9;
  localparam logic [3:0] S_REJ   = 4'd10;
  localparam logic [3:0] S_TCHK  = 4'd11;
  localparam logic [3:0] S_TCMP  = 4'd12;
  localparam logic [3:0] S_TFIN  = 4'd13;

  logic [3:0] state_r;
  logic [3:0] state_nxt;

  assign in_tready = (state_r == S_IDLE);

  always_comb begin
    state_nxt = state_r;
    ctl.op    = dtq_pkg::OP_NONE;
    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          ctl.op = dtq_pkg::OP_LOAD;
          case (in_command)
            CMD_PLAY:  state_nxt = S_PCHK;
            CMD_TICK:  state_nxt = S_TCHK;
            CMD_CLEAR: state_nxt = S_CLR;
            default:   state_nxt = S_IDLE;
          endcase
        end
      end
      S_CLR: begin
        ctl.op    = dtq_pkg::OP_CLEAR;
        state_nxt = S_IDLE;
      end
      S_PCHK: begin
        state_nxt = sts.full ? S_REJ : S_PWALK;
      end
      S_PWALK: begin
        if (sts.walk_end) begin
          state_nxt = S_SHCHK;
        end else begin
          ctl.op    = dtq_pkg::OP_RD_POS;
          state_nxt = S_PCMP;
        end
      end
      S_PCMP: begin
        ctl.op    = dtq_pkg::OP_WALK_STEP;
        state_nxt = sts.walk_hit ? S_SHCHK : S_PWALK;
      end
      S_SHCHK: begin
        if (sts.shift_done) begin
          state_nxt = S_WNEW;
        end else begin
          ctl.op    = dtq_pkg::OP_RD_SHIFT;
          state_nxt = S_SHWR;
        end
      end
      S_SHWR: begin
        ctl.op    = dtq_pkg::OP_WR_SHIFT;
        state_nxt = S_SHCHK;
      end
      S_WNEW: begin
        ctl.op    = dtq_pkg::OP_WR_NEW;
        state_nxt = sts.pos_lt_len ? S_WSUCC : S_PDONE;
      end
      S_WSUCC: begin
        ctl.op    = dtq_pkg::OP_WR_SUCC;
        state_nxt = S_PDONE;
      end
      S_PDONE: begin
        if (sts.out_free) begin
          ctl.op    = dtq_pkg::OP_COMMIT;
          state_nxt = S_IDLE;
        end
      end
      S_REJ: begin
        if (sts.out_free) begin
          ctl.op    = dtq_pkg::OP_REJECT;
          state_nxt = S_IDLE;
        end
      end
      S_TCHK: begin
        if (sts.q_empty) begin
          state_nxt = S_TFIN;
        end else begin
          ctl.op    = dtq_pkg::OP_RD_HEAD;
          state_nxt = S_TCMP;
        end
      end
      S_TCMP: begin
        if (sts.head_expire) begin
          if (!sts.pend_valid || sts.out_free) begin
            ctl.op    = dtq_pkg::OP_TICK_POP;
            state_nxt = S_TCHK;
          end
        end else begin
          ctl.op    = dtq_pkg::OP_TICK_SUB;
          state_nxt = S_TFIN;
        end
      end
      S_TFIN: begin
        if (!sts.pend_valid) begin
          state_nxt = S_IDLE;
        end else if (sts.out_free) begin
          ctl.op    = dtq_pkg::OP_TICK_LAST;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

[hdl/dtq_dp.sv]
module dtq_dp #(
  parameter int MAX_VOICES = 16,
  parameter int TIME_BITS  = 24
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic [47:0]       in_tdata,
  input  dtq_pkg::dtq_ctl_t ctl,
  output dtq_pkg::dtq_sts_t sts,
  input  logic              out_tready,
  output logic              out_tvalid,
  output logic [7:0]        out_tdata,
  output logic [1:0]        out_tuser,
  output logic              out_tlast
);

  localparam int AW = (MAX_VOICES > 1) ? $clog2(MAX_VOICES) : 1;
  localparam int LW = $clog2(MAX_VOICES + 1);
  localparam int SW = LW + 1;
  localparam int TB = TIME_BITS;
  localparam int MW = TB + AW;

  localparam logic [1:0] KIND_OK   = 2'd0;
  localparam logic [1:0] KIND_REJ  = 2'd1;
  localparam logic [1:0] KIND_DONE = 2'd2;

  function automatic logic [AW-1:0] phys(input logic [AW-1:0] h, input logic [LW-1:0] off);
    logic [SW-1:0] s;
    s = SW'(h) + SW'(off);
    if (s >= SW'(MAX_VOICES)) begin
      s = s - SW'(MAX_VOICES);
    end
    return AW'(s);
  endfunction

  logic [MW-1:0]         mem [MAX_VOICES];
  logic [MW-1:0]         rdata_r;
  logic                  rd_en;
  logic [AW-1:0]         rd_addr;
  logic                  wr_en;
  logic [AW-1:0]         wr_addr;
  logic [MW-1:0]         wr_data;

  logic [LW-1:0]         len_r, len_nxt;
  logic [AW-1:0]         head_r, head_nxt;
  logic [MAX_VOICES-1:0] flags_r, flags_nxt;
  logic                  pend_valid_r, pend_valid_nxt;
  logic                  out_valid_r, out_valid_nxt;

  logic [TB-1:0]         dur_r, dur_nxt;
  logic [TB-1:0]         rem_r, rem_nxt;
  logic [TB-1:0]         before_r, before_nxt;
  logic [LW-1:0]         pos_r, pos_nxt;
  logic [LW-1:0]         j_r, j_nxt;
  logic [TB-1:0]         hit_delta_r, hit_delta_nxt;
  logic [AW-1:0]         hit_slot_r, hit_slot_nxt;
  logic [AW-1:0]         pend_slot_r, pend_slot_nxt;
  logic [1:0]            out_kind_r, out_kind_nxt;
  logic [3:0]            out_voice_r, out_voice_nxt;
  logic                  out_last_r, out_last_nxt;

  logic [TB-1:0]         rdelta;
  logic [AW-1:0]         rslot;
  logic [TB:0]           reach;
  logic [TB-1:0]         new_delta;
  logic [AW-1:0]         free_slot;
  logic                  free_found;
  logic                  out_free;

  assign rdelta    = rdata_r[TB-1:0];
  assign rslot     = rdata_r[MW-1:TB];
  assign reach     = (TB+1)'(before_r) + (TB+1)'(rdelta);
  assign new_delta = dur_r - before_r;
  assign out_free  = !out_valid_r || out_tready;

  always_comb begin
    free_found = 1'b0;
    free_slot  = '0;
    for (int i = MAX_VOICES - 1; i >= 0; i--) begin
      if (!flags_r[i]) begin
        free_found = 1'b1;
        free_slot  = AW'(i);
      end
    end
  end

  always_comb begin
    sts.full        = !free_found || (len_r == LW'(MAX_VOICES));
    sts.walk_end    = (pos_r == len_r);
    sts.walk_hit    = ((TB+1)'(dur_r) <= reach);
    sts.shift_done  = (j_r == pos_r);
    sts.pos_lt_len  = (pos_r < len_r);
    sts.q_empty     = (len_r == '0);
    sts.head_expire = (rdelta <= rem_r);
    sts.pend_valid  = pend_valid_r;
    sts.out_free    = out_free;
  end

  always_comb begin
    rd_en   = 1'b0;
    rd_addr = head_r;
    wr_en   = 1'b0;
    wr_addr = head_r;
    wr_data = rdata_r;
    case (ctl.op)
      dtq_pkg::OP_RD_POS: begin
        rd_en   = 1'b1;
        rd_addr = phys(head_r, pos_r);
      end
      dtq_pkg::OP_RD_SHIFT: begin
        rd_en   = 1'b1;
        rd_addr = phys(head_r, j_r - LW'(1));
      end
      dtq_pkg::OP_RD_HEAD: begin
        rd_en = 1'b1;
      end
      dtq_pkg::OP_WR_SHIFT: begin
        wr_en   = 1'b1;
        wr_addr = phys(head_r, j_r);
      end
      dtq_pkg::OP_WR_NEW: begin
        wr_en   = 1'b1;
        wr_addr = phys(head_r, pos_r);
        wr_data = {free_slot, new_delta};
      end
      dtq_pkg::OP_WR_SUCC: begin
        wr_en   = 1'b1;
        wr_addr = phys(head_r, pos_r + LW'(1));
        wr_data = {hit_slot_r, hit_delta_r - new_delta};
      end
      dtq_pkg::OP_TICK_SUB: begin
        wr_en   = 1'b1;
        wr_data = {rslot, rdelta - rem_r};
      end
      default: begin
        rd_en = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rdata_r <= mem[rd_addr];
    end
  end

  always_comb begin
    len_nxt        = len_r;
    head_nxt       = head_r;
    flags_nxt      = flags_r;
    pend_valid_nxt = pend_valid_r;
    out_valid_nxt  = out_valid_r && !out_tready;
    dur_nxt        = dur_r;
    rem_nxt        = rem_r;
    before_nxt     = before_r;
    pos_nxt        = pos_r;
    j_nxt          = j_r;
    hit_delta_nxt  = hit_delta_r;
    hit_slot_nxt   = hit_slot_r;
    pend_slot_nxt  = pend_slot_r;
    out_kind_nxt   = out_kind_r;
    out_voice_nxt  = out_voice_r;
    out_last_nxt   = out_last_r;
    case (ctl.op)
      dtq_pkg::OP_LOAD: begin
        dur_nxt        = TB'(in_tdata[23:0]);
        rem_nxt        = TB'(in_tdata[47:24]);
        before_nxt     = '0;
        pos_nxt        = '0;
        j_nxt          = len_r;
        pend_valid_nxt = 1'b0;
      end
      dtq_pkg::OP_CLEAR: begin
        len_nxt   = '0;
        head_nxt  = '0;
        flags_nxt = '0;
      end
      dtq_pkg::OP_WALK_STEP: begin
        if (sts.walk_hit) begin
          hit_delta_nxt = rdelta;
          hit_slot_nxt  = rslot;
        end else begin
          before_nxt = TB'(reach);
          pos_nxt    = pos_r + LW'(1);
        end
      end
      dtq_pkg::OP_WR_SHIFT: begin
        j_nxt = j_r - LW'(1);
      end
      dtq_pkg::OP_COMMIT: begin
        flags_nxt     = flags_r | (MAX_VOICES'(1) << free_slot);
        len_nxt       = len_r + LW'(1);
        out_valid_nxt = 1'b1;
        out_kind_nxt  = KIND_OK;
        out_voice_nxt = 4'(free_slot);
        out_last_nxt  = 1'b1;
      end
      dtq_pkg::OP_REJECT: begin
        out_valid_nxt = 1'b1;
        out_kind_nxt  = KIND_REJ;
        out_voice_nxt = '0;
        out_last_nxt  = 1'b1;
      end
      dtq_pkg::OP_TICK_POP: begin
        rem_nxt   = rem_r - rdelta;
        flags_nxt = flags_r & ~(MAX_VOICES'(1) << rslot);
        head_nxt  = phys(head_r, LW'(1));
        len_nxt   = len_r - LW'(1);
        if (pend_valid_r) begin
          out_valid_nxt = 1'b1;
          out_kind_nxt  = KIND_DONE;
          out_voice_nxt = 4'(pend_slot_r);
          out_last_nxt  = 1'b0;
        end
        pend_slot_nxt  = rslot;
        pend_valid_nxt = 1'b1;
      end
      dtq_pkg::OP_TICK_LAST: begin
        out_valid_nxt  = 1'b1;
        out_kind_nxt   = KIND_DONE;
        out_voice_nxt  = 4'(pend_slot_r);
        out_last_nxt   = 1'b1;
        pend_valid_nxt = 1'b0;
      end
      default: begin
        len_nxt = len_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r        <= '0;
      head_r       <= '0;
      flags_r      <= '0;
      pend_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      len_r        <= len_nxt;
      head_r       <= head_nxt;
      flags_r      <= flags_nxt;
      pend_valid_r <= pend_valid_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    dur_r       <= dur_nxt;
    rem_r       <= rem_nxt;
    before_r    <= before_nxt;
    pos_r       <= pos_nxt;
    j_r         <= j_nxt;
    hit_delta_r <= hit_delta_nxt;
    hit_slot_r  <= hit_slot_nxt;
    pend_slot_r <= pend_slot_nxt;
    out_kind_r  <= out_kind_nxt;
    out_voice_r <= out_voice_nxt;
    out_last_r  <= out_last_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {4'b0000, out_voice_r};
  assign out_tuser  = out_kind_r;
  assign out_tlast  = out_last_r;

endmodule

[hdl/delta_timer_queue_slots_unit.sv]
// channel  | dir | tdata                                  | tuser       | tlast
// in_      | in  | duration [23:0], elapsed [47:24]       | command     | -
// out_     | out | voice [3:0], zero [7:4]                | kind        | last
//
// play: walks the queued entries, moves later entries up, writes the new entry and, when
//   it goes in front of an entry, rewrites that entry's delta; a rejected play only reports;
//   the queue memory takes one read or write at a time, with registered read data
// tick: pops and reports expired entries, cuts the remaining head; clear: empties queue
// reset clears queue length, in-use flags and handshake state at once, no sweep
// one output register; the controller stalls before loading a result while the last is not taken
module delta_timer_queue_slots_unit #(
  parameter int MAX_VOICES = 16,
  parameter int TIME_BITS  = 24
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [47:0] in_tdata,   // duration, elapsed
  input  logic [1:0]  in_tuser,   // command
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,  // voice, zero pad
  output logic [1:0]  out_tuser,  // kind
  output logic        out_tlast
);

  dtq_pkg::dtq_ctl_t ctl;
  dtq_pkg::dtq_sts_t sts;

  dtq_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_command (in_tuser),
    .sts        (sts),
    .ctl        (ctl)
  );

  dtq_dp #(
    .MAX_VOICES (MAX_VOICES),
    .TIME_BITS  (TIME_BITS)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .ctl        (ctl),
    .sts        (sts),
    .out_tready (out_tready),
    .out_tvalid (out_tvalid),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule

[verif/voice_queue_checker.sv]
`timescale 1ns / 100ps

package voice_tb_pkg;

  typedef enum logic [1:0] {
    CMD_PLAY  = 2'd0,
    CMD_TICK  = 2'd1,
    CMD_CLEAR = 2'd2,
    CMD_SPARE = 2'd3
  } voice_cmd_t;

  typedef enum logic [1:0] {
    EV_STARTED  = 2'd0,
    EV_REJECTED = 2'd1,
    EV_FINISHED = 2'd2
  } voice_event_t;

  typedef struct packed {
    voice_event_t kind;
    logic [3:0]   voice;
    logic         last;
  } voice_report_t;

endpackage

module voice_queue_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [47:0] in_tdata,
  input  logic [1:0]  in_tuser,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [7:0]  out_tdata,
  input  logic [1:0]  out_tuser,
  input  logic        out_tlast,
  output int          errors,
  output int          outstanding,
  output int          reports_seen,
  output int          voices_finished,
  output int          plays_rejected
);

  localparam int SLOTS = 16;

  logic [23:0]                 rel_time [SLOTS];
  logic [3:0]                  slot_of [SLOTS];
  int                          depth;
  logic [15:0]                 busy;
  voice_tb_pkg::voice_report_t pending_reports [$];

  function automatic void add_report(voice_tb_pkg::voice_event_t k, logic [3:0] v, logic l);
    voice_tb_pkg::voice_report_t r;
    r.kind  = k;
    r.voice = v;
    r.last  = l;
    pending_reports.insert(pending_reports.size(), r);
  endfunction

  function automatic void start_voice(logic [23:0] dur);
    int          s;
    int          pos;
    int          n;
    logic [63:0] ahead;
    logic [63:0] diff;
    ahead = '0;
    for (s = 0; s < SLOTS && busy[s]; s++);
    if (s >= SLOTS || depth >= SLOTS) begin
      add_report(voice_tb_pkg::EV_REJECTED, 4'd0, 1'b1);
      return;
    end
    busy[s] = 1'b1;
    n = depth;
    pos = 0;
    // the walk stops at an entry of equal absolute time, so a tie lands in front of it
    while (pos < n && !({40'd0, dur} <= ahead + {40'd0, rel_time[pos]})) begin
      ahead += {40'd0, rel_time[pos]};
      pos++;
    end
    for (int j = n; j > pos; j--) begin
      rel_time[j] = rel_time[j-1];
      slot_of[j]  = slot_of[j-1];
    end
    diff = {40'd0, dur} - ahead;
    rel_time[pos] = diff[23:0];
    slot_of[pos]  = s[3:0];
    if (pos < n)
      rel_time[pos+1] = rel_time[pos+1] - rel_time[pos];
    depth = n + 1;
    add_report(voice_tb_pkg::EV_STARTED, s[3:0], 1'b1);
  endfunction

  function automatic void advance_time(logic [23:0] el);
    logic [63:0]                 rem;
    int                          count;
    int                          idx;
    logic                        running;
    voice_tb_pkg::voice_report_t tail;
    rem = {40'd0, el};
    count = 0;
    running = 1'b1;
    while (running && depth > 0) begin
      if ({40'd0, rel_time[0]} > rem) begin
        rel_time[0] = rel_time[0] - rem[23:0];
        running = 1'b0;
      end else begin
        // overshoot carries into the next entry
        rem -= {40'd0, rel_time[0]};
        busy[slot_of[0]] = 1'b0;
        add_report(voice_tb_pkg::EV_FINISHED, slot_of[0], 1'b0);
        count++;
        for (int j = 1; j < depth; j++) begin
          rel_time[j-1] = rel_time[j];
          slot_of[j-1]  = slot_of[j];
        end
        depth--;
      end
    end
    if (count > 0) begin
      idx = pending_reports.size() - 1;
      tail = pending_reports[idx];
      tail.last = 1'b1;
      pending_reports[idx] = tail;
    end
  endfunction

  always @(posedge clk) begin
    voice_tb_pkg::voice_report_t want;
    if (!rst_n) begin
      depth = 0;
      busy = '0;
      pending_reports.delete();
      errors = 0;
      outstanding = 0;
      reports_seen = 0;
      voices_finished = 0;
      plays_rejected = 0;
    end else begin
      // results leave before a new transaction can affect them
      if (out_tvalid && out_tready) begin
        reports_seen++;
        if (out_tuser == voice_tb_pkg::EV_FINISHED)
          voices_finished++;
        if (out_tuser == voice_tb_pkg::EV_REJECTED)
          plays_rejected++;
        if (pending_reports.size() == 0) begin
          $error("unexpected result: kind %0d voice %0d last %0d",
                 out_tuser, out_tdata[3:0], out_tlast);
          errors++;
        end else begin
          want = pending_reports.pop_front();
          if (out_tuser !== want.kind) begin
            $error("kind: expected %0d, actual %0d", want.kind, out_tuser);
            errors++;
          end
          if (out_tdata[3:0] !== want.voice) begin
            $error("voice: expected %0d, actual %0d", want.voice, out_tdata[3:0]);
            errors++;
          end
          if (out_tlast !== want.last) begin
            $error("last: expected %0d, actual %0d", want.last, out_tlast);
            errors++;
          end
          if (out_tdata[7:4] !== 4'd0) begin
            $error("pad: expected 0, actual %0d", out_tdata[7:4]);
            errors++;
          end
        end
      end
      if (in_tvalid && in_tready) begin
        case (voice_tb_pkg::voice_cmd_t'(in_tuser))
          voice_tb_pkg::CMD_PLAY: begin
            start_voice(in_tdata[23:0]);
          end
          voice_tb_pkg::CMD_TICK: begin
            advance_time(in_tdata[47:24]);
          end
          voice_tb_pkg::CMD_CLEAR: begin
            depth = 0;
            busy = '0;
          end
          default: begin
          end
        endcase
      end
      outstanding = pending_reports.size();
    end
  end

endmodule

[verif/delta_timer_queue_slots_unit_tb.sv]
`timescale 1ns / 100ps

module delta_timer_queue_slots_unit_tb;

  localparam int QUIET_LIMIT = 2000;
  localparam int HOLD_CYCLES = 300;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [47:0] in_tdata = '0;
  logic [1:0]  in_tuser = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [7:0]  out_tdata;
  logic [1:0]  out_tuser;
  logic        out_tlast;

  int   errors;
  int   outstanding;
  int   reports_seen;
  int   voices_finished;
  int   plays_rejected;
  int   quiet_cycles = 0;
  int   cmd_tally [4] = '{0, 0, 0, 0};
  logic steady = 1'b0;
  logic hold_request = 1'b0;
  logic hold_done = 1'b0;

  delta_timer_queue_slots_unit #(
    .MAX_VOICES(16),
    .TIME_BITS (24)
  ) uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .out_tlast (out_tlast)
  );

  voice_queue_checker checker_i (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_tvalid      (in_tvalid),
    .in_tready      (in_tready),
    .in_tdata       (in_tdata),
    .in_tuser       (in_tuser),
    .out_tvalid     (out_tvalid),
    .out_tready     (out_tready),
    .out_tdata      (out_tdata),
    .out_tuser      (out_tuser),
    .out_tlast      (out_tlast),
    .errors         (errors),
    .outstanding    (outstanding),
    .reports_seen   (reports_seen),
    .voices_finished(voices_finished),
    .plays_rejected (plays_rejected)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  function automatic logic [23:0] any24();
    return 24'($urandom());
  endfunction

  task automatic send_cmd(input voice_tb_pkg::voice_cmd_t cmd, input logic [23:0] dur,
                          input logic [23:0] el);
    while (!steady && $urandom_range(99) < 29) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= cmd;
    in_tdata  <= {el, dur};
    do @(posedge clk); while (!in_tready);
    cmd_tally[cmd]++;
    @(negedge clk);
  endtask

  // result side: random stalls, plus one long hold-off on request
  initial begin
    forever begin
      @(negedge clk);
      if (hold_request && !hold_done) begin
        hold_done = 1'b1;
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end else if (!steady && $urandom_range(99) < 29) begin
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready))
        quiet_cycles <= 0;
      else
        quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("Verification failed");
        $finish;
      end
    end
  end

  initial begin
    int                       counted;
    int                       pick;
    int                       sel;
    logic [23:0]              dur;
    logic [23:0]              el;
    voice_tb_pkg::voice_cmd_t cmd;

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed: empty tick, spare code, full pool with ties and extremes
    send_cmd(voice_tb_pkg::CMD_TICK, any24(), 24'd0);
    send_cmd(voice_tb_pkg::CMD_SPARE, any24(), any24());
    send_cmd(voice_tb_pkg::CMD_PLAY, 24'd0, any24());
    send_cmd(voice_tb_pkg::CMD_PLAY, 24'hFFFFFF, any24());
    send_cmd(voice_tb_pkg::CMD_PLAY, 24'd100, any24());
    send_cmd(voice_tb_pkg::CMD_PLAY, 24'd100, any24());
    send_cmd(voice_tb_pkg::CMD_PLAY, 24'd200, any24());
    send_cmd(voice_tb_pkg::CMD_PLAY, 24'hFFFFFF, any24());
    for (int i = 0; i < 10; i++)
      send_cmd(voice_tb_pkg::CMD_PLAY, 24'($urandom_range(1000, 1)), any24());
    send_cmd(voice_tb_pkg::CMD_PLAY, 24'd77, any24());
    send_cmd(voice_tb_pkg::CMD_TICK, any24(), 24'd0);
    send_cmd(voice_tb_pkg::CMD_TICK, any24(), 24'd150);
    send_cmd(voice_tb_pkg::CMD_CLEAR, any24(), any24());
    send_cmd(voice_tb_pkg::CMD_PLAY, 24'd5, any24());
    send_cmd(voice_tb_pkg::CMD_TICK, 24'd0, 24'hFFFFFF);

    counted = 0;
    while (counted < 96) begin
      dur  = any24();
      el   = any24();
      pick = $urandom_range(99);
      if (counted >= 20 && counted < 40 && pick >= 6)
        pick = 10;
      if (pick < 3) begin
        cmd = voice_tb_pkg::CMD_SPARE;
      end else if (pick < 6) begin
        cmd = voice_tb_pkg::CMD_CLEAR;
      end else if (pick < 52) begin
        cmd = voice_tb_pkg::CMD_PLAY;
        sel = $urandom_range(99);
        if (sel < 60)
          dur = 24'($urandom_range(600));
        else if (sel < 75)
          dur = 24'(100 * $urandom_range(4, 1));
        else if (sel < 90)
          dur = any24();
        else
          dur = (sel < 95) ? 24'd0 : 24'hFFFFFF;
      end else begin
        cmd = voice_tb_pkg::CMD_TICK;
        sel = $urandom_range(99);
        if (sel < 50)
          el = 24'($urandom_range(300));
        else if (sel < 65)
          el = 24'd0;
        else if (sel < 85)
          el = 24'($urandom_range(2000, 300));
        else if (sel < 95)
          el = any24();
        else
          el = 24'hFFFFFF;
      end
      if (cmd != voice_tb_pkg::CMD_SPARE) begin
        counted++;
        if (counted == 90)
          hold_request = 1'b1;
      end
      steady = (counted >= 40 && counted < 70);
      send_cmd(cmd, dur, el);
    end
    steady = 1'b0;
    in_tvalid <= 1'b0;

    wait (outstanding == 0);
    repeat (100) @(posedge clk);

    $display("commands sent: %0d play, %0d tick, %0d clear, %0d spare code",
             cmd_tally[voice_tb_pkg::CMD_PLAY], cmd_tally[voice_tb_pkg::CMD_TICK],
             cmd_tally[voice_tb_pkg::CMD_CLEAR], cmd_tally[voice_tb_pkg::CMD_SPARE]);
    $display("results checked: %0d, voices finished %0d, plays rejected %0d",
             reports_seen, voices_finished, plays_rejected);
    if (errors == 0 && outstanding == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

endmodule
